// ===== rtl/arpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and protocol constants for the ARP cache engine.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam logic [1:0]  CMD_PACKET  = 2'd0;
  localparam logic [1:0]  CMD_RESOLVE = 2'd1;
  localparam logic [1:0]  CMD_FLUSH   = 2'd2;

  localparam logic [15:0] HTYPE_ETH    = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  HLEN_ETH     = 8'd6;
  localparam logic [7:0]  PLEN_IPV4    = 8'd4;
  localparam logic [15:0] ARPOP_REQ    = 16'd1;
  localparam logic [15:0] ARPOP_RPL    = 16'd2;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_MISS     = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_INSERTED = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_DROPPED  = 3'd5,
    STAT_FLUSHED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_LEARN,
    OP_RESOLVE,
    OP_FLUSH,
    OP_DROP
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     reply;
  } decode_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/arpc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_len;
  logic [7:0]  proto_len;
  logic [15:0] operation;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [31:0] lookup_ip;

  modport source (
    output valid, command, hw_type, proto_type, hw_len, proto_len, operation,
           sender_mac, sender_ip, target_ip, lookup_ip,
    input  ready
  );
  modport sink (
    input  valid, command, hw_type, proto_type, hw_len, proto_len, operation,
           sender_mac, sender_ip, target_ip, lookup_ip,
    output ready
  );
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] resolved_mac;
  logic        reply_needed;

  modport source (
    output valid, status, resolved_mac, reply_needed,
    input  ready
  );
  modport sink (
    input  valid, status, resolved_mac, reply_needed,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/arpc_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache command decoder
// Classifies an incoming word and checks the ARP header fields.
// ----------------------------------------------------------------------------
module arpc_decode (
  input  wire logic [1:0]  command,
  input  wire logic [15:0] hw_type,
  input  wire logic [15:0] proto_type,
  input  wire logic [7:0]  hw_len,
  input  wire logic [7:0]  proto_len,
  input  wire logic [15:0] operation,
  input  wire logic [31:0] target_ip,
  input  wire logic [31:0] local_ip,
  output arpc_pkg::decode_t dec
);

  logic hdr_ok;

  assign hdr_ok = (hw_type == arpc_pkg::HTYPE_ETH) && (proto_type == arpc_pkg::PTYPE_IPV4) &&
                  (hw_len == arpc_pkg::HLEN_ETH) && (proto_len == arpc_pkg::PLEN_IPV4) &&
                  ((operation == arpc_pkg::ARPOP_REQ) ||
                   (operation == arpc_pkg::ARPOP_RPL));

  always_comb begin
    dec.reply = 1'b0;
    case (command)
      arpc_pkg::CMD_PACKET: begin
        if (hdr_ok) begin
          dec.kind  = arpc_pkg::OP_LEARN;
          dec.reply = (target_ip == local_ip) && (operation == arpc_pkg::ARPOP_REQ);
        end else begin
          dec.kind = arpc_pkg::OP_DROP;
        end
      end
      arpc_pkg::CMD_RESOLVE: dec.kind = arpc_pkg::OP_RESOLVE;
      arpc_pkg::CMD_FLUSH:   dec.kind = arpc_pkg::OP_FLUSH;
      default:               dec.kind = arpc_pkg::OP_DROP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/arpc_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache table memory
// Single-port-write, single-port-read entry store with registered read data.
// ----------------------------------------------------------------------------
module arpc_table #(
  parameter int CACHE_ENTRIES = 16,
  parameter int AW            = 4
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output arpc_pkg::entry_t       rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire arpc_pkg::entry_t  wr_data
);

  arpc_pkg::entry_t mem [CACHE_ENTRIES];
  arpc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/arpc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache controller
// Clears the table memory after reset and on flush, scans it for one word
// at a time, then writes back and registers the result word.
// ----------------------------------------------------------------------------
module arpc_ctrl #(
  parameter int CACHE_ENTRIES = 16,
  parameter int AW            = 4,
  parameter int CW            = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  arpc_in_if.sink                in_item,
  arpc_out_if.source             out_item,
  input  wire arpc_pkg::decode_t dec,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  wire arpc_pkg::entry_t  rd_data,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output arpc_pkg::entry_t       wr_data
);

  localparam logic [CW-1:0] LAST_CNT = CW'(CACHE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_ENTRIES - 1);

  arpc_pkg::state_t   state_r, state_nxt;
  arpc_pkg::op_kind_t kind_r, kind_nxt;
  logic               reply_r, reply_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [47:0]        mac_in_r, mac_in_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [AW-1:0]      chk_r, chk_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               found_r, found_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [47:0]        hit_mac_r, hit_mac_nxt;
  logic               free_r, free_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               out_vld_r, out_vld_nxt;
  arpc_pkg::status_t  out_status_r, out_status_nxt;
  logic [47:0]        out_mac_r, out_mac_nxt;
  logic               out_reply_r, out_reply_nxt;
  logic               accept;
  logic               scan_last;
  logic               out_free;

  assign in_item.ready = (state_r == arpc_pkg::ST_IDLE);
  assign accept    = in_item.valid && in_item.ready;
  assign scan_last = rd_vld_r && (chk_r == LAST_IDX);
  assign out_free  = !out_vld_r || out_item.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_INIT: begin
        if (clr_r == LAST_IDX) begin
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          case (dec.kind)
            arpc_pkg::OP_LEARN, arpc_pkg::OP_RESOLVE: state_nxt = arpc_pkg::ST_SCAN;
            arpc_pkg::OP_FLUSH:                      state_nxt = arpc_pkg::ST_FLUSH;
            default:                                 state_nxt = arpc_pkg::ST_DONE;
          endcase
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = arpc_pkg::ST_DONE;
        end
      end
      arpc_pkg::ST_FLUSH: begin
        if (clr_r == LAST_IDX) begin
          state_nxt = arpc_pkg::ST_DONE;
        end
      end
      arpc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = arpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt       = kind_r;
    reply_nxt      = reply_r;
    key_nxt        = key_r;
    mac_in_nxt     = mac_in_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    rd_vld_nxt     = 1'b0;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    clr_nxt        = clr_r;
    out_vld_nxt    = out_vld_r && !out_item.ready;
    out_status_nxt = out_status_r;
    out_mac_nxt    = out_mac_r;
    out_reply_nxt  = out_reply_r;
    rd_en          = 1'b0;
    rd_addr        = iss_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = clr_r;
    wr_data        = '0;

    case (state_r)
      arpc_pkg::ST_INIT, arpc_pkg::ST_FLUSH: begin
        wr_en   = 1'b1;
        clr_nxt = (clr_r == LAST_IDX) ? '0 : clr_r + 1'b1;
      end
      arpc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt   = dec.kind;
          reply_nxt  = dec.reply;
          key_nxt    = (dec.kind == arpc_pkg::OP_RESOLVE) ? in_item.lookup_ip
                                                          : in_item.sender_ip;
          mac_in_nxt = in_item.sender_mac;
          iss_nxt    = '0;
          found_nxt  = 1'b0;
          free_nxt   = 1'b0;
          clr_nxt    = '0;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (iss_r < LAST_CNT) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          chk_nxt    = iss_r[AW-1:0];
          iss_nxt    = iss_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_data.vld && (rd_data.ip == key_r) && !found_r) begin
            found_nxt   = 1'b1;
            hit_idx_nxt = chk_r;
            hit_mac_nxt = rd_data.mac;
          end
          if (!rd_data.vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_r;
          end
        end
      end
      arpc_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_mac_nxt   = '0;
          out_reply_nxt = 1'b0;
          wr_data.vld   = 1'b1;
          wr_data.ip    = key_r;
          wr_data.mac   = mac_in_r;
          case (kind_r)
            arpc_pkg::OP_LEARN: begin
              out_reply_nxt = reply_r;
              if (found_r) begin
                wr_en          = 1'b1;
                wr_addr        = hit_idx_r;
                out_status_nxt = arpc_pkg::STAT_UPDATED;
              end else if (free_r) begin
                wr_en          = 1'b1;
                wr_addr        = free_idx_r;
                out_status_nxt = arpc_pkg::STAT_INSERTED;
              end else begin
                out_status_nxt = arpc_pkg::STAT_FULL;
              end
            end
            arpc_pkg::OP_RESOLVE: begin
              if (found_r) begin
                out_status_nxt = arpc_pkg::STAT_HIT;
                out_mac_nxt    = hit_mac_r;
              end else begin
                out_status_nxt = arpc_pkg::STAT_MISS;
              end
            end
            arpc_pkg::OP_FLUSH: out_status_nxt = arpc_pkg::STAT_FLUSHED;
            default:            out_status_nxt = arpc_pkg::STAT_DROPPED;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= arpc_pkg::ST_INIT;
      clr_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    reply_r      <= reply_nxt;
    key_r        <= key_nxt;
    mac_in_r     <= mac_in_nxt;
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_mac_r    <= out_mac_nxt;
    out_reply_r  <= out_reply_nxt;
  end

  assign out_item.valid        = out_vld_r;
  assign out_item.status       = out_status_r;
  assign out_item.resolved_mac = out_mac_r;
  assign out_item.reply_needed = out_reply_r;

endmodule
`default_nettype wire

// ===== rtl/arp_cache_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache engine
// IPv4-over-Ethernet ARP cache: learns sender mappings from received
// packets, resolves addresses and flushes on command.
// ----------------------------------------------------------------------------
// Words enter on in_item (valid/ready) and each one yields exactly one
// result word on out_item (valid/ready). The local IP address is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while the
// engine is idle, since the engine itself does not enforce this. The table
// lives in one synchronous memory that is scanned one entry per cycle.
// A flush word clears the table instead of a scan; a dropped word skips both.
// One word is processed at a time; the next word can be accepted once the
// previous result has been placed in the output register.
// After reset the engine clears every entry of the table memory before it
// accepts the first word. Configuration writes are taken then.
// When the receiver stalls, the result word holds in the output register
// and the next word completes its scan and then waits for it to drain.
// ----------------------------------------------------------------------------
module arp_cache_engine #(
  parameter int CACHE_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  arpc_in_if.sink          in_item,
  arpc_out_if.source       out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);

  logic [31:0]       local_ip_r;
  arpc_pkg::decode_t dec;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  arpc_pkg::entry_t  rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  arpc_pkg::entry_t  wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_wr_en) begin
      local_ip_r <= cfg_wr_data;
    end
  end

  arpc_decode u_decode (
    .command    (in_item.command),
    .hw_type    (in_item.hw_type),
    .proto_type (in_item.proto_type),
    .hw_len     (in_item.hw_len),
    .proto_len  (in_item.proto_len),
    .operation  (in_item.operation),
    .target_ip  (in_item.target_ip),
    .local_ip   (local_ip_r),
    .dec        (dec)
  );

  arpc_table #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .AW            (AW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  arpc_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .dec      (dec),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP cache engine testbench
// Sends packet, resolve, flush and malformed words with random gaps on both channels.
// A scoreboard class keeps its own copy of the cache table and the local
// address and checks every result word in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         TABLE_SLOTS     = 16;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         DRAIN_CYCLES    = 40;
  localparam int         WORDS_PER_PHASE = 350;
  localparam int         RANDOM_PHASES   = 4;
  localparam int         POOL_SIZE       = 24;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;

  typedef struct {
    logic [1:0]  command;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] operation;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] lookup_ip;
  } arp_word_t;

  typedef struct {
    arpc_pkg::status_t status;
    logic [47:0]       mac;
    logic              reply;
  } arp_result_t;

  class arp_table_mirror;
    logic [31:0] local_ip;
    bit          slot_valid [TABLE_SLOTS];
    logic [31:0] slot_ip [TABLE_SLOTS];
    logic [47:0] slot_mac [TABLE_SLOTS];
    arp_result_t awaited_results [$];
    int          error_count;

    function new();
      local_ip = '0;
      error_count = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function int find_ip(logic [31:0] ip);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_valid[i] && slot_ip[i] == ip) return i;
      end
      return TABLE_SLOTS;
    endfunction

    function int find_free();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (!slot_valid[i]) return i;
      end
      return TABLE_SLOTS;
    endfunction

    function void note_word(arp_word_t w);
      arp_result_t r;
      int          s;
      bit          well_formed;
      r.status = arpc_pkg::STAT_DROPPED;
      r.mac = '0;
      r.reply = 1'b0;
      well_formed = w.hw_type == arpc_pkg::HTYPE_ETH &&
                    w.proto_type == arpc_pkg::PTYPE_IPV4 &&
                    w.hw_len == arpc_pkg::HLEN_ETH && w.proto_len == arpc_pkg::PLEN_IPV4 &&
                    (w.operation == arpc_pkg::ARPOP_REQ ||
                     w.operation == arpc_pkg::ARPOP_RPL);
      case (w.command)
        arpc_pkg::CMD_PACKET: begin
          if (well_formed) begin
            s = find_ip(w.sender_ip);
            if (s < TABLE_SLOTS) begin
              slot_mac[s] = w.sender_mac;
              r.status = arpc_pkg::STAT_UPDATED;
            end else begin
              s = find_free();
              if (s < TABLE_SLOTS) begin
                slot_valid[s] = 1'b1;
                slot_ip[s] = w.sender_ip;
                slot_mac[s] = w.sender_mac;
                r.status = arpc_pkg::STAT_INSERTED;
              end else begin
                r.status = arpc_pkg::STAT_FULL;
              end
            end
            r.reply = (w.target_ip == local_ip) && (w.operation == arpc_pkg::ARPOP_REQ);
          end
        end
        arpc_pkg::CMD_RESOLVE: begin
          s = find_ip(w.lookup_ip);
          if (s < TABLE_SLOTS) begin
            r.status = arpc_pkg::STAT_HIT;
            r.mac = slot_mac[s];
          end else begin
            r.status = arpc_pkg::STAT_MISS;
          end
        end
        arpc_pkg::CMD_FLUSH: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          r.status = arpc_pkg::STAT_FLUSHED;
        end
        default: begin
        end
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [47:0] mac, logic reply);
      arp_result_t r;
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with nothing expected, status %0d", $time, status);
        return;
      end
      r = awaited_results.pop_front();
      if (status !== r.status) begin
        error_count++;
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
      end
      if (mac !== r.mac) begin
        error_count++;
        $display("%0t: resolved_mac expected %h actual %h", $time, r.mac, mac);
      end
      if (reply !== r.reply) begin
        error_count++;
        $display("%0t: reply_needed expected %b actual %b", $time, r.reply, reply);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  arpc_in_if  in_ch ();
  arpc_out_if out_ch ();

  arp_table_mirror table_mirror = new();
  bit              send_idle_on = 1'b1;
  bit              recv_idle_on = 1'b1;
  int              words_sent = 0;
  logic [31:0]     ip_pool [POOL_SIZE];

  arp_cache_engine #(
    .CACHE_ENTRIES(TABLE_SLOTS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_ch),
    .out_item   (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [47:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[47:0];
  endfunction

  function automatic logic [31:0] pool_ip();
    return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic arp_word_t scrambled_word();
    arp_word_t w;
    w.command = 2'($urandom());
    w.hw_type = 16'($urandom());
    w.proto_type = 16'($urandom());
    w.hw_len = 8'($urandom());
    w.proto_len = 8'($urandom());
    w.operation = 16'($urandom());
    w.sender_mac = random_mac();
    w.sender_ip = $urandom();
    w.target_ip = $urandom();
    w.lookup_ip = $urandom();
    return w;
  endfunction

  function automatic arp_word_t packet_word(logic [15:0] op, logic [47:0] mac,
                                            logic [31:0] sip, logic [31:0] tip);
    arp_word_t w;
    w = scrambled_word();
    w.command = arpc_pkg::CMD_PACKET;
    w.hw_type = arpc_pkg::HTYPE_ETH;
    w.proto_type = arpc_pkg::PTYPE_IPV4;
    w.hw_len = arpc_pkg::HLEN_ETH;
    w.proto_len = arpc_pkg::PLEN_IPV4;
    w.operation = op;
    w.sender_mac = mac;
    w.sender_ip = sip;
    w.target_ip = tip;
    return w;
  endfunction

  function automatic arp_word_t resolve_word(logic [31:0] ip);
    arp_word_t w;
    w = scrambled_word();
    w.command = arpc_pkg::CMD_RESOLVE;
    w.lookup_ip = ip;
    return w;
  endfunction

  function automatic arp_word_t random_word();
    arp_word_t   w;
    int          pick;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [15:0] op;
    pick = $urandom_range(0, 99);
    op = $urandom_range(0, 1) ? arpc_pkg::ARPOP_REQ : arpc_pkg::ARPOP_RPL;
    sip = ($urandom_range(0, 19) == 0) ? $urandom() : pool_ip();
    if ($urandom_range(0, 2) == 0) tip = table_mirror.local_ip;
    else tip = $urandom_range(0, 1) ? pool_ip() : $urandom();
    w = packet_word(op, random_mac(), sip, tip);
    if (pick < 2) begin
      w = scrambled_word();
      w.command = arpc_pkg::CMD_FLUSH;
    end else if (pick < 40) begin
      w = resolve_word(($urandom_range(0, 7) == 0) ? $urandom() : pool_ip());
    end else if (pick >= 88 && pick < 98) begin
      case ($urandom_range(0, 4))
        0: w.hw_type = 16'($urandom());
        1: w.proto_type = 16'($urandom());
        2: w.hw_len = 8'($urandom());
        3: w.proto_len = 8'($urandom());
        default: w.operation = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom());
      endcase
    end else if (pick >= 98) begin
      w = scrambled_word();
      w.command = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input arp_word_t w);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= w.command;
    in_ch.hw_type <= w.hw_type;
    in_ch.proto_type <= w.proto_type;
    in_ch.hw_len <= w.hw_len;
    in_ch.proto_len <= w.proto_len;
    in_ch.operation <= w.operation;
    in_ch.sender_mac <= w.sender_mac;
    in_ch.sender_ip <= w.sender_ip;
    in_ch.target_ip <= w.target_ip;
    in_ch.lookup_ip <= w.lookup_ip;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    table_mirror.note_word(w);
    words_sent++;
    if (words_sent % 64 == 0) send_idle_on = ($urandom_range(0, 2) != 0);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (table_mirror.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_local_ip(input logic [31:0] ip);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ip;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    table_mirror.local_ip = ip;
  endtask

  task automatic collect_results();
    int gap;
    int taken;
    taken = 0;
    forever begin
      gap = recv_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      table_mirror.check_result(out_ch.status, out_ch.resolved_mac, out_ch.reply_needed);
      taken++;
      if (taken % 64 == 0) recv_idle_on = ($urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("arp_cache_engine test failed");
    $finish;
  end

  initial begin
    arp_word_t   directed_words [$];
    arp_word_t   w;
    logic [31:0] home_ip;
    logic [31:0] phase_ip;

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= arpc_pkg::CMD_PACKET;
    in_ch.hw_type <= '0;
    in_ch.proto_type <= '0;
    in_ch.hw_len <= '0;
    in_ch.proto_len <= '0;
    in_ch.operation <= '0;
    in_ch.sender_mac <= '0;
    in_ch.sender_ip <= '0;
    in_ch.target_ip <= '0;
    in_ch.lookup_ip <= '0;
    out_ch.ready <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none

    home_ip = $urandom();
    write_local_ip(home_ip);

    directed_words.push_back(resolve_word(32'h0000_0000));
    directed_words.push_back(packet_word(arpc_pkg::ARPOP_REQ, 48'h0, 32'h0000_0000,
                                         home_ip));
    directed_words.push_back(packet_word(arpc_pkg::ARPOP_RPL, 48'hFFFF_FFFF_FFFF,
                                         32'hFFFF_FFFF, home_ip));
    directed_words.push_back(packet_word(arpc_pkg::ARPOP_REQ, random_mac(), 32'h0000_0000,
                                         ~home_ip));
    directed_words.push_back(resolve_word(32'hFFFF_FFFF));
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.hw_type = 16'hFFFF;
    directed_words.push_back(w);
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.proto_type = 16'h0806;
    directed_words.push_back(w);
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.hw_len = 8'hFF;
    directed_words.push_back(w);
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.proto_len = 8'h00;
    directed_words.push_back(w);
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.operation = 16'hFFFF;
    directed_words.push_back(w);
    w = packet_word(arpc_pkg::ARPOP_REQ, random_mac(), $urandom(), home_ip);
    w.command = CMD_UNUSED;
    directed_words.push_back(w);
    for (int i = 0; i < TABLE_SLOTS - 2; i++) begin
      directed_words.push_back(packet_word(arpc_pkg::ARPOP_RPL, random_mac(),
                                           32'h0A00_0000 + i, home_ip));
    end
    directed_words.push_back(packet_word(arpc_pkg::ARPOP_REQ, random_mac(), 32'h0B00_0000,
                                         home_ip));
    w = scrambled_word();
    w.command = arpc_pkg::CMD_FLUSH;
    directed_words.push_back(w);
    foreach (directed_words[i]) send_word(directed_words[i]);

    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      hold_until_drained();
      if (p == 0) phase_ip = 32'h0000_0000;
      else if (p == 1) phase_ip = 32'hFFFF_FFFF;
      else phase_ip = ($urandom_range(0, 1) == 0) ? pool_ip() : $urandom();
      write_local_ip(phase_ip);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(random_word());
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_mirror.error_count == 0) begin
      $display("arp_cache_engine test passed");
    end else begin
      $display("arp_cache_engine test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/arpc_pkg.sv
rtl/arpc_if.sv
rtl/arpc_decode.sv
rtl/arpc_table.sv
rtl/arpc_ctrl.sv
rtl/arp_cache_engine.sv
tb/testbench.sv
